### src/fts_pkg.sv
// shared constants, types and helper functions for the fixed-timestep pacer
// no dependencies; used by fts_mul, fts_div and fixed_timestep_pacer_core
package fts_pkg;

  localparam int TIME_W  = 32;  // timestamp width
  localparam int PCT_W   = 10;  // speed percent width
  localparam int BANK_W  = 31;  // banked time, hundredths of a microsecond
  localparam int FRAME_W = 27;  // frame interval times 100
  localparam int IVL_W   = 20;  // frame interval in microseconds
  localparam int STEPS_W = 5;   // steps owed per tick
  localparam int CARRY_W = 7;   // timer carry, percent
  localparam int IDX_W   = 2;   // configuration register index

  localparam logic [PCT_W-1:0]   PCT_MIN      = 10'd100;
  localparam logic [PCT_W-1:0]   PCT_MAX      = 10'd1000;
  localparam logic [IVL_W-1:0]   IVL_MIN      = 20'd1;
  localparam logic [IVL_W-1:0]   IVL_MAX      = 20'd1000000;
  localparam logic [FRAME_W-1:0] FRAME_RESET  = 27'd1666700;
  localparam logic [FRAME_W-1:0] TIMER_DIV    = 27'd100;
  localparam logic [STEPS_W-1:0] TIMER_CAP    = 5'd31;
  localparam logic [STEPS_W-1:0] STEPS_MAX    = 5'd20;
  localparam logic [STEPS_W-1:0] ONE_STEP     = 5'd1;

  // configuration register indexes
  localparam logic [IDX_W-1:0] REG_VSYNC_MODE    = 2'd0;
  localparam logic [IDX_W-1:0] REG_TURBO_PERCENT = 2'd1;
  localparam logic [IDX_W-1:0] REG_FRAME_IVL     = 2'd2;

  // start request into the serial multiply-accumulate unit
  typedef struct packed {
    logic              start;
    logic [TIME_W-1:0] now;
    logic [TIME_W-1:0] last;
    logic [PCT_W-1:0]  pct;
    logic [BANK_W-1:0] bank;
  } mul_req_t;

  // start request into the repeated-subtract divider
  typedef struct packed {
    logic               start;
    logic [BANK_W-1:0]  dividend;
    logic [FRAME_W-1:0] divisor;
    logic [STEPS_W-1:0] cap;
  } div_req_t;

  typedef struct packed {
    logic busy;
    logic done;
  } unit_stat_t;

  // ceil(2 * pct / 100) = floor((pct + 49) / 50), via reciprocal 1311 / 2^16
  function automatic logic [STEPS_W-1:0] catchup_limit(input logic [PCT_W-1:0] pct);
    logic [10:0] t;
    logic [21:0] p;
    t = {1'b0, pct} + 11'd49;
    p = {11'b0, t} * 22'd1311;
    return p[20:16];
  endfunction

endpackage

### src/fts_mul.sv
// bit-serial elapsed-time multiply-accumulate: (now - last) * pct + bank
// one timestamp bit per cycle, lsb first; depends on fts_pkg
module fts_mul (
  input  logic                      clk,
  input  logic                      rst,
  input  fts_pkg::mul_req_t         req,
  output fts_pkg::unit_stat_t       stat,
  output logic [fts_pkg::BANK_W-1:0] product
);

  logic [fts_pkg::TIME_W-1:0] now_sr;
  logic [fts_pkg::TIME_W-1:0] last_sr;
  logic [fts_pkg::BANK_W-1:0] bank_sr;
  logic [fts_pkg::PCT_W-1:0]  pct;
  logic                       borrow;
  logic [10:0]                hi;
  logic [fts_pkg::TIME_W-1:0] lo;
  logic [4:0]                 cnt;
  logic                       busy;
  logic                       done;

  logic        e_bit;
  logic        borrow_next;
  logic [11:0] sum;

  always_comb begin
    // serial subtract gives elapsed bit i at cycle i
    e_bit       = now_sr[0] ^ last_sr[0] ^ borrow;
    borrow_next = (~now_sr[0] & last_sr[0]) | (~(now_sr[0] ^ last_sr[0]) & borrow);
    // bank bit i enters as carry at the weight of hi[0]
    sum = {1'b0, hi} + (e_bit ? {2'b0, pct} : 12'd0) + {11'd0, bank_sr[0]};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        now_sr  <= req.now;
        last_sr <= req.last;
        bank_sr <= req.bank;
        pct     <= req.pct;
        borrow  <= 1'b0;
        hi      <= '0;
        lo      <= '0;
        cnt     <= '0;
        busy    <= 1'b1;
      end else if (busy) begin
        now_sr  <= {1'b0, now_sr[fts_pkg::TIME_W-1:1]};
        last_sr <= {1'b0, last_sr[fts_pkg::TIME_W-1:1]};
        bank_sr <= {1'b0, bank_sr[fts_pkg::BANK_W-1:1]};
        borrow  <= borrow_next;
        hi      <= sum[11:1];
        lo      <= {sum[0], lo[fts_pkg::TIME_W-1:1]};
        cnt     <= cnt + 5'd1;
        if (cnt == 5'd31) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // anything at or above 2^31 is past every possible ceiling
  assign product = (|hi || lo[fts_pkg::TIME_W-1]) ? '1 : lo[fts_pkg::BANK_W-1:0];
  assign stat.busy = busy;
  assign stat.done = done;

endmodule

### src/fts_div.sv
// capped repeated-subtract divider, one subtraction per cycle
// quotient stops at cap, and then the remainder is cleared; depends on fts_pkg
module fts_div (
  input  logic                        clk,
  input  logic                        rst,
  input  fts_pkg::div_req_t           req,
  output fts_pkg::unit_stat_t         stat,
  output logic [fts_pkg::STEPS_W-1:0] quot,
  output logic [fts_pkg::BANK_W-1:0]  rem
);

  logic [fts_pkg::FRAME_W-1:0] dvs;
  logic [fts_pkg::STEPS_W-1:0] cap;
  logic                        busy;
  logic                        done;
  logic                        ge;

  assign ge = rem >= {{(fts_pkg::BANK_W-fts_pkg::FRAME_W){1'b0}}, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        rem  <= req.dividend;
        dvs  <= req.divisor;
        cap  <= req.cap;
        quot <= '0;
        busy <= 1'b1;
      end else if (busy) begin
        if (quot != cap && ge) begin
          rem  <= rem - {{(fts_pkg::BANK_W-fts_pkg::FRAME_W){1'b0}}, dvs};
          quot <= quot + 5'd1;
        end else begin
          // hitting the cap means the bank was at or over the ceiling
          if (quot == cap) rem <= '0;
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign stat.busy = busy;
  assign stat.done = done;

endmodule

### src/fixed_timestep_pacer_core.sv
// top level of the fixed-timestep pacer: config registers, tick sequencer, output register
// depends on fts_pkg, fts_mul and fts_div
//
// usage: each tick arrives on the s_axis channel (tdata = timestamp in us, tuser = turbo
// key held); the block answers one transaction on m_axis with the steps the tick owes.
// configuration is written through cfg_we / cfg_index / cfg_data while no tick is pending:
// index 0 = schedule mode (writing it clears the carry, bank and timing state),
// index 1 = turbo percent, index 2 = frame interval in us (both saturate to range).
// path from input transaction to result: a plain timer tick or the first display tick
// goes straight to the output stage, a turbo timer tick runs the subtracting divider
// (one subtraction per cycle, at most 10), and a display tick runs the bit-serial
// elapsed-time multiplier, then the subtracting divider.
// one tick is in flight at a time; the next tick is taken as soon as the sequencer is
// idle, even while the previous result still waits in the output register.
// a stalled receiver holds m_axis_tvalid and the data; a finished tick waits for the
// output register before s_axis_tready comes back.
// reset (rst, synchronous) restores timer mode, 100 percent turbo, a 16667 us frame,
// clears the carry, bank and timing state and empties the output register.
module fixed_timestep_pacer_core (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      s_axis_tvalid,
  output logic                      s_axis_tready,
  input  logic [31:0]               s_axis_tdata,   // [31:0] now_us
  input  logic [0:0]                s_axis_tuser,   // [0] turbo_held
  output logic                      m_axis_tvalid,
  input  logic                      m_axis_tready,
  output logic [7:0]                m_axis_tdata,   // [4:0] steps_owed, [7:5] zero
  input  logic                      cfg_we,
  input  logic [fts_pkg::IDX_W-1:0] cfg_index,
  input  logic [19:0]               cfg_data
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MUL,
    ST_DIV,
    ST_DONE
  } state_t;

  state_t state;

  // configuration
  logic                        vsync_mode;
  logic [fts_pkg::PCT_W-1:0]   turbo_pct;
  logic [fts_pkg::FRAME_W-1:0] frame;

  // pacing state
  logic [fts_pkg::CARRY_W-1:0] step_carry;
  logic [fts_pkg::BANK_W-1:0]  time_bank;
  logic [fts_pkg::TIME_W-1:0]  last_time;
  logic                        started;

  // per-tick working registers
  logic [fts_pkg::STEPS_W-1:0] cap_q;
  logic [fts_pkg::STEPS_W-1:0] steps_q;
  logic                        timer_path;
  logic [fts_pkg::STEPS_W-1:0] out_steps;
  logic                        out_valid;

  fts_pkg::mul_req_t   mul_req;
  fts_pkg::div_req_t   div_req;
  fts_pkg::unit_stat_t mul_stat;
  fts_pkg::unit_stat_t div_stat;
  logic [fts_pkg::BANK_W-1:0]  mul_product;
  logic [fts_pkg::STEPS_W-1:0] div_quot;
  logic [fts_pkg::BANK_W-1:0]  div_rem;

  logic                        in_xfer;
  logic                        held;
  logic [fts_pkg::PCT_W-1:0]   pct_in;
  logic [fts_pkg::CARRY_W-1:0] carry_eff;
  logic [10:0]                 timer_sum;
  logic [fts_pkg::PCT_W-1:0]   turbo_sat;
  logic [fts_pkg::IVL_W-1:0]   ivl_sat;
  logic [fts_pkg::FRAME_W-1:0] frame_next;
  logic                        out_free;

  assign s_axis_tready = (state == ST_IDLE);
  assign in_xfer       = s_axis_tvalid && s_axis_tready;
  assign held          = s_axis_tuser[0];
  assign out_free      = !out_valid || m_axis_tready;

  always_comb begin
    pct_in    = held ? turbo_pct : fts_pkg::PCT_MIN;
    carry_eff = held ? step_carry : '0;
    timer_sum = {4'd0, carry_eff} + {1'b0, pct_in};

    if (cfg_data[9:0] < fts_pkg::PCT_MIN)      turbo_sat = fts_pkg::PCT_MIN;
    else if (cfg_data[9:0] > fts_pkg::PCT_MAX) turbo_sat = fts_pkg::PCT_MAX;
    else                                       turbo_sat = cfg_data[9:0];

    if (cfg_data < fts_pkg::IVL_MIN)      ivl_sat = fts_pkg::IVL_MIN;
    else if (cfg_data > fts_pkg::IVL_MAX) ivl_sat = fts_pkg::IVL_MAX;
    else                                  ivl_sat = cfg_data;

    // interval * 100 = x*64 + x*32 + x*4
    frame_next = ({7'd0, ivl_sat} << 6) + ({7'd0, ivl_sat} << 5) + ({7'd0, ivl_sat} << 2);
  end

  fts_mul u_mul (
    .clk     (clk),
    .rst     (rst),
    .req     (mul_req),
    .stat    (mul_stat),
    .product (mul_product)
  );

  fts_div u_div (
    .clk  (clk),
    .rst  (rst),
    .req  (div_req),
    .stat (div_stat),
    .quot (div_quot),
    .rem  (div_rem)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      vsync_mode    <= 1'b0;
      turbo_pct     <= fts_pkg::PCT_MIN;
      frame         <= fts_pkg::FRAME_RESET;
      step_carry    <= '0;
      time_bank     <= '0;
      last_time     <= '0;
      started       <= 1'b0;
      out_valid     <= 1'b0;
      mul_req.start <= 1'b0;
      div_req.start <= 1'b0;
      timer_path    <= 1'b0;
    end else begin
      mul_req.start <= 1'b0;
      div_req.start <= 1'b0;
      if (out_valid && m_axis_tready) out_valid <= 1'b0;

      unique case (state)
        ST_IDLE: begin
          if (in_xfer) begin
            step_carry <= carry_eff;
            if (!vsync_mode) begin
              timer_path <= 1'b1;
              if (pct_in == fts_pkg::PCT_MIN) begin
                steps_q <= fts_pkg::ONE_STEP;
                state   <= ST_DONE;
              end else begin
                div_req.start    <= 1'b1;
                div_req.dividend <= {{(fts_pkg::BANK_W-11){1'b0}}, timer_sum};
                div_req.divisor  <= fts_pkg::TIMER_DIV;
                div_req.cap      <= fts_pkg::TIMER_CAP;
                state            <= ST_DIV;
              end
            end else if (!started) begin
              started   <= 1'b1;
              last_time <= s_axis_tdata;
              steps_q   <= fts_pkg::ONE_STEP;
              state     <= ST_DONE;
            end else begin
              timer_path    <= 1'b0;
              mul_req.start <= 1'b1;
              mul_req.now   <= s_axis_tdata;
              mul_req.last  <= last_time;
              mul_req.pct   <= pct_in;
              mul_req.bank  <= time_bank;
              last_time     <= s_axis_tdata;
              cap_q         <= fts_pkg::catchup_limit(pct_in);
              state         <= ST_MUL;
            end
          end
        end
        ST_MUL: begin
          if (mul_stat.done) begin
            div_req.start    <= 1'b1;
            div_req.dividend <= mul_product;
            div_req.divisor  <= frame;
            div_req.cap      <= cap_q;
            state            <= ST_DIV;
          end
        end
        ST_DIV: begin
          if (div_stat.done) begin
            steps_q <= div_quot;
            if (timer_path) step_carry <= div_rem[fts_pkg::CARRY_W-1:0];
            else            time_bank  <= div_rem;
            state <= ST_DONE;
          end
        end
        ST_DONE: begin
          if (out_free) begin
            out_valid <= 1'b1;
            out_steps <= steps_q;
            state     <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase

      if (cfg_we) begin
        unique case (cfg_index)
          fts_pkg::REG_VSYNC_MODE: begin
            vsync_mode <= cfg_data[0];
            step_carry <= '0;
            time_bank  <= '0;
            last_time  <= '0;
            started    <= 1'b0;
          end
          fts_pkg::REG_TURBO_PERCENT: turbo_pct <= turbo_sat;
          fts_pkg::REG_FRAME_IVL:     frame     <= frame_next;
          default: ;
        endcase
      end
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {3'd0, out_steps};

`ifndef SYNTHESIS
  // the timer carry is a remainder of 100
  a_carry_range: assert property (@(posedge clk) disable iff (rst)
    step_carry < 7'd100)
    else $error("timer carry out of range");

  // a result never exceeds the largest catch-up count
  a_steps_range: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> out_steps <= fts_pkg::STEPS_MAX)
    else $error("steps owed exceeds catch-up limit");

  // multiplier and divider never run on the same tick at once
  a_units_exclusive: assert property (@(posedge clk) disable iff (rst)
    !(mul_stat.busy && div_stat.busy))
    else $error("multiplier and divider busy together");

  // an accepted tick closes the input until its result is queued
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    in_xfer |=> !s_axis_tready)
    else $error("second tick accepted while one is in flight");
`endif

endmodule

### tb/fixed_timestep_pacer_core_tb.sv
// self-checking testbench for fixed_timestep_pacer_core: a scoreboard class predicts the steps
// owed by each accepted tick and checks every result in order; plain tasks drive ticks and config
// depends on fts_pkg and the fixed_timestep_pacer_core RTL
module fixed_timestep_pacer_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  typedef longint unsigned u64_t;

  localparam int CATCHUP_FRAMES = 2;
  localparam logic [fts_pkg::IDX_W-1:0] REG_UNUSED = 2'd3;
  localparam int PHASES = 30;

  class step_ledger;
    bit                          mode;
    logic [fts_pkg::PCT_W-1:0]   turbo_pct;
    logic [fts_pkg::IVL_W-1:0]   ivl;
    logic [fts_pkg::CARRY_W-1:0] carry;
    logic [31:0]                 bank;
    logic [fts_pkg::TIME_W-1:0]  last_seen;
    bit                          started;
    logic [fts_pkg::STEPS_W-1:0] owed_q[$];
    int                          errors;

    function new();
      mode = 1'b0;
      turbo_pct = fts_pkg::PCT_MIN;
      ivl = 20'd16667;
      errors = 0;
      clear_timing();
    endfunction

    function void clear_timing();
      carry = '0;
      bank = '0;
      last_seen = '0;
      started = 1'b0;
    endfunction

    function int pending();
      return owed_q.size();
    endfunction

    function void write_reg(logic [fts_pkg::IDX_W-1:0] idx, logic [19:0] data);
      logic [fts_pkg::PCT_W-1:0] p;
      logic [fts_pkg::IVL_W-1:0] v;
      case (idx)
        fts_pkg::REG_VSYNC_MODE: begin
          mode = data[0];
          clear_timing();
        end
        fts_pkg::REG_TURBO_PERCENT: begin
          p = data[fts_pkg::PCT_W-1:0];
          if (p < fts_pkg::PCT_MIN) p = fts_pkg::PCT_MIN;
          if (p > fts_pkg::PCT_MAX) p = fts_pkg::PCT_MAX;
          turbo_pct = p;
        end
        fts_pkg::REG_FRAME_IVL: begin
          v = data[fts_pkg::IVL_W-1:0];
          if (v < fts_pkg::IVL_MIN) v = fts_pkg::IVL_MIN;
          if (v > fts_pkg::IVL_MAX) v = fts_pkg::IVL_MAX;
          ivl = v;
        end
        default: ;
      endcase
    endfunction

    // works out the steps one accepted tick owes and queues them
    function void book_tick(logic [fts_pkg::TIME_W-1:0] now, bit held);
      logic [fts_pkg::PCT_W-1:0]   pct;
      logic [10:0]                 sum;
      logic [fts_pkg::TIME_W-1:0]  dt;
      u64_t                        frame, cap, fill, whole;
      logic [fts_pkg::STEPS_W-1:0] owed;
      pct = (held && turbo_pct > fts_pkg::PCT_MIN) ? turbo_pct : fts_pkg::PCT_MIN;
      if (!held) carry = '0;
      if (!mode) begin
        if (pct == fts_pkg::PCT_MIN) begin
          owed = fts_pkg::ONE_STEP;
        end else begin
          sum = carry + pct;
          owed = fts_pkg::STEPS_W'(sum / 100);
          carry = fts_pkg::CARRY_W'(sum % 100);
        end
      end else if (!started) begin
        started = 1'b1;
        last_seen = now;
        owed = fts_pkg::ONE_STEP;
      end else begin
        dt = now - last_seen;
        cap = (u64_t'(pct) * CATCHUP_FRAMES + 99) / 100;
        frame = u64_t'(ivl) * 100;
        fill = u64_t'(bank) + u64_t'(dt) * u64_t'(pct);
        last_seen = now;
        // a long stall is absorbed at the ceiling, not replayed
        if (fill > frame * cap) fill = frame * cap;
        whole = fill / frame;
        if (whole > cap) whole = cap;
        fill = fill - whole * frame;
        bank = 32'(fill);
        owed = fts_pkg::STEPS_W'(whole);
      end
      owed_q.push_back(owed);
    endfunction

    task flag_mismatch(string what);
      $display("mismatch at %0t: %s", $realtime, what);
      errors++;
    endtask

    task settle_result(logic [7:0] data);
      logic [fts_pkg::STEPS_W-1:0] want;
      if (owed_q.size() == 0) begin
        flag_mismatch($sformatf("result %0d with no tick outstanding", data));
      end else begin
        want = owed_q.pop_front();
        if (data !== {3'b000, want})
          flag_mismatch($sformatf("steps_owed got %0d, want %0d", data, want));
      end
    endtask
  endclass

  logic                        clk;
  logic                        rst;
  logic                        s_axis_tvalid;
  logic                        s_axis_tready;
  logic [31:0]                 s_axis_tdata;   // [31:0] now_us
  logic [0:0]                  s_axis_tuser;   // [0] turbo_held
  logic                        m_axis_tvalid;
  logic                        m_axis_tready;
  logic [7:0]                  m_axis_tdata;   // [4:0] steps_owed, [7:5] zero
  logic                        cfg_we;
  logic [fts_pkg::IDX_W-1:0]   cfg_index;
  logic [19:0]                 cfg_data;

  step_ledger  sb;
  int          send_idle = 35;
  int          recv_idle = 88;
  logic [31:0] t_cur;
  bit          turbo;

  fixed_timestep_pacer_core dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  always begin
    clk = 1'b0;
    #1;
    clk = 1'b1;
    #1;
  end

  // tvalid is left high after a transaction so back-to-back ticks need no extra edge
  task send_tick(logic [31:0] now, bit held);
    while ($urandom_range(99) < send_idle) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= now;
    s_axis_tuser  <= held;
    do @(posedge clk); while (!s_axis_tready);
    sb.book_tick(now, held);
  endtask

  task hold_until_drained();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk); while (sb.pending() != 0);
  endtask

  task cfg_write(logic [fts_pkg::IDX_W-1:0] idx, logic [19:0] data);
    hold_until_drained();
    repeat (3) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    cfg_we    <= 1'b0;
    sb.write_reg(idx, data);
  endtask

  // next display timestamp: mostly about a frame or a few later, with stalls, repeats and wraps
  function logic [31:0] next_stamp();
    case ($urandom_range(0, 19))
      0: t_cur = $urandom;
      1: t_cur = t_cur + $urandom;
      2: ;
      3: t_cur = 32'hFFFF_FFFF - $urandom_range(0, sb.ivl * 2);
      default: t_cur = t_cur + sb.ivl * $urandom_range(0, 12) / 4 + $urandom_range(0, sb.ivl / 8);
    endcase
    return t_cur;
  endfunction

  task configure_phase(bit first);
    logic [19:0] pct_val, ivl_val;
    case ($urandom_range(0, 7))
      0: pct_val = 20'd100;
      1: pct_val = 20'd1000;
      2: pct_val = 20'($urandom_range(100, 1000));
      3: pct_val = 20'($urandom_range(101, 199));
      4: pct_val = 20'($urandom_range(0, 20'hFFFFF));
      5: pct_val = 20'($urandom_range(0, 99));
      6: pct_val = 20'($urandom_range(1001, 1023));
      default: pct_val = 20'd200;
    endcase
    case ($urandom_range(0, 7))
      0: ivl_val = 20'd1;
      1: ivl_val = 20'd1000000;
      2: ivl_val = 20'($urandom_range(2, 200));
      3: ivl_val = 20'd16667;
      4: ivl_val = 20'($urandom_range(1000, 50000));
      5: ivl_val = 20'($urandom_range(0, 20'hFFFFF));
      6: ivl_val = 20'd0;
      default: ivl_val = 20'($urandom_range(1000001, 20'hFFFFF));
    endcase
    cfg_write(fts_pkg::REG_TURBO_PERCENT, pct_val);
    cfg_write(fts_pkg::REG_FRAME_IVL, ivl_val);
    if ($urandom_range(9) == 0) cfg_write(REG_UNUSED, 20'($urandom_range(0, 20'hFFFFF)));
    // skipping the mode write carries timing state into the new settings
    if (first || $urandom_range(99) < 70)
      cfg_write(fts_pkg::REG_VSYNC_MODE,
                {19'($urandom_range(0, 20'h7FFFF)),
                 (($urandom_range(99) < 60) ? 1'b1 : 1'b0)});
  endtask

  initial begin
    m_axis_tready <= 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && m_axis_tvalid && m_axis_tready) sb.settle_result(m_axis_tdata);
      m_axis_tready <= ($urandom_range(99) >= recv_idle);
    end
  end

  initial begin
    #2_000_000;
    $display("Some tests failed");
    $finish;
  end

  initial begin
    int n;
    sb = new();
    rst           <= 1'b1;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    s_axis_tuser  <= '0;
    cfg_we        <= 1'b0;
    cfg_index     <= '0;
    cfg_data      <= '0;
    t_cur = '0;
    turbo = 1'b0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // timer schedule at reset settings, then turbo carry and its release
    send_tick(32'h0000_0000, 1'b0);
    send_tick(32'hFFFF_FFFF, 1'b1);
    cfg_write(fts_pkg::REG_TURBO_PERCENT, 20'h003FF);
    send_tick(32'h1234_5678, 1'b1);
    cfg_write(fts_pkg::REG_TURBO_PERCENT, 20'hFFC96);
    send_tick(32'h0000_0001, 1'b1);
    send_tick(32'h0000_0002, 1'b1);
    send_tick(32'h0000_0003, 1'b1);
    send_tick(32'h0000_0004, 1'b0);
    send_tick(32'h0000_0005, 1'b1);
    cfg_write(fts_pkg::REG_TURBO_PERCENT, 20'd5);
    cfg_write(fts_pkg::REG_FRAME_IVL, 20'd0);
    cfg_write(fts_pkg::REG_FRAME_IVL, 20'hFFFFF);
    cfg_write(fts_pkg::REG_FRAME_IVL, 20'd16667);
    cfg_write(REG_UNUSED, 20'hFFFFF);
    // display schedule: start, wrap across zero, repeat stamp, turbo ceiling, long stall
    cfg_write(fts_pkg::REG_VSYNC_MODE, 20'd1);
    send_tick(32'hFFFF_FFF0, 1'b0);
    send_tick(32'h0000_4110, 1'b0);
    send_tick(32'h0000_4110, 1'b0);
    cfg_write(fts_pkg::REG_TURBO_PERCENT, 20'd1000);
    send_tick(32'h0001_0490, 1'b1);
    send_tick(32'hF000_0000, 1'b1);
    cfg_write(fts_pkg::REG_FRAME_IVL, 20'd1);
    send_tick(32'hF000_0001, 1'b1);
    send_tick(32'h7000_0000, 1'b1);
    cfg_write(fts_pkg::REG_VSYNC_MODE, 20'd1);
    send_tick(32'h0000_0000, 1'b1);
    send_tick(32'h8000_0000, 1'b0);
    cfg_write(fts_pkg::REG_VSYNC_MODE, 20'd0);
    send_tick(32'h5555_5555, 1'b1);
    send_tick(32'hAAAA_AAAA, 1'b1);

    for (int ph = 0; ph < PHASES; ph++) begin
      send_idle = (ph < PHASES / 3) ? 35 : (ph < 2 * PHASES / 3) ? 88 : 0;
      recv_idle = (ph < PHASES / 3) ? 88 : (ph < 2 * PHASES / 3) ? 35 : 0;
      configure_phase(ph == 0);
      t_cur = $urandom;
      n = $urandom_range(25, 50);
      for (int i = 0; i < n; i++) begin
        if ($urandom_range(99) < 2) hold_until_drained();
        if ($urandom_range(99) >= 80) turbo = !turbo;
        if (sb.mode) send_tick(next_stamp(), turbo);
        else send_tick($urandom, turbo);
      end
    end

    hold_until_drained();
    repeat (64) @(posedge clk);
    if (sb.errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
